// ===== rtl/boundary_tag_heap_allocator_defines.svh =====
// Assertion macros shared by the checker of the boundary-tag heap allocator.
// Depends on nothing; included by the checker file.
`ifndef BOUNDARY_TAG_HEAP_ALLOCATOR_DEFINES_SVH
`define BOUNDARY_TAG_HEAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define BTH_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bth assertion failed");

// Next-cycle implication, disabled while reset is active.
`define BTH_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bth assertion failed");

`endif

// ===== rtl/bth_pkg.sv =====
// Constants, codes and bus widths of the boundary-tag heap allocator.
// Depends on nothing; used by the top level and its checker.
`default_nettype none

package bth_pkg;

    localparam int HEAP_BYTES = 4096;
    localparam int HEAP_WORDS = HEAP_BYTES / 4;
    localparam int IDX_W      = $clog2(HEAP_WORDS);

    localparam logic [31:0] HEAP_LIMIT = 32'(HEAP_BYTES);
    localparam logic [31:0] TAG_BYTES  = 32'd4;
    localparam logic [31:0] MIN_CHUNK  = 32'd12;

    localparam int S_DATA_W = 104;
    localparam int M_DATA_W = 72;

    typedef enum logic [2:0] {
        OP_ALLOC  = 3'd0,
        OP_FREE   = 3'd1,
        OP_RESIZE = 3'd2,
        OP_CALLOC = 3'd3,
        OP_WALK   = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NULL     = 3'd1,
        ST_BIG      = 3'd2,
        ST_OOM      = 3'd3,
        ST_CORRUPT  = 3'd4,
        ST_BADPTR   = 3'd5,
        ST_NOTALLOC = 3'd6
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/boundary_tag_heap_allocator.sv =====
// Boundary-tag first-fit heap allocator: top level with tag store and sequencer.
// Depends on bth_pkg.
// Walk and allocate read the tags of the blocks one after another from offset 0.
// Resize does at most an allocate plus a free.
// One transfer is processed at a time through a single tag-store read port.
// After reset a clearing pass over all HEAP_WORDS (1024) words rebuilds the store.
`default_nettype none

module boundary_tag_heap_allocator import bth_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // opcode, pointer, request_size, element_count (from bit 0 up)
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // result_pointer, status, block_count, free_bytes, used_bytes (from bit 0 up)
    output logic [M_DATA_W-1:0] m_tdata,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [31:0]         cfg_data
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_MUL, S_A_INIT, S_A_RD, S_A_CHK, S_FRESH_H, S_FRESH_F,
        S_SP_H1, S_SP_F1, S_SP_H2, S_SP_F2, S_F_START, S_F_TAG, S_FH, S_FF,
        S_F_NRD, S_F_NCHK, S_F_PRD, S_F_PCHK, S_F_PRD2, S_F_PTAG,
        S_R_START, S_R_TAG, S_W_RD, S_W_CHK, S_OUT
    } state_t;

    typedef enum logic [1:0] {FM_NORMAL, FM_ZERO, FM_QUIET} fmode_t;
    typedef enum logic [1:0] {FR_NEXT, FR_PREV, FR_DONE} fret_t;

    state_t              state_reg, state_next;
    fmode_t              fmode_reg, fmode_next;
    fret_t               fret_reg, fret_next;
    status_t             st_reg, st_next;
    logic [31:0]         ptr_reg, ptr_next, size_reg, size_next, cnt_reg, cnt_next;
    logic [31:0]         base_reg, base_next;
    logic [32:0]         asize_reg, asize_next;
    logic [31:0]         need_reg, need_next, off_reg, off_next;
    logic [31:0]         wa_reg, wa_next, rest_reg, rest_next;
    logic [31:0]         fsize_reg, fsize_next, foff_reg, foff_next, psz_reg, psz_next;
    logic [31:0]         res_reg, res_next;
    logic                split_reg, split_next, mv_reg, mv_next;
    logic [8:0]          blocks_reg, blocks_next;
    logic [12:0]         fb_reg, fb_next, ub_reg, ub_next;
    logic [IDX_W-1:0]    clr_reg, clr_next;
    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    logic [31:0]         mem [HEAP_WORDS];
    logic [31:0]         rd_data_reg;
    logic                rd_en, wr_req, wr_en;
    logic [31:0]         rd_off, wr_off, wr_val;
    logic [IDX_W-1:0]    rd_idx, wr_idx;

    logic [31:0]         tag, bsz, p_off, aneed, prod;
    logic                p_bad;
    logic [32:0]         rsz;
    logic [33:0]         rneed;
    logic [2:0]          in_op;

    function automatic status_t free_final(fmode_t m, status_t s);
        status_t r;
        case (m)
            FM_QUIET: r = ST_OK;
            FM_ZERO:  r = (s == ST_OK) ? ST_NULL : s;
            default:  r = s;
        endcase
        return r;
    endfunction

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign cfg_ready = 1'b1;
    assign in_op     = s_tdata[2:0];

    assign rd_idx = rd_off[IDX_W+1:2];
    assign wr_idx = wr_off[IDX_W+1:2];
    assign wr_en  = wr_req && (wr_off < HEAP_LIMIT);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_val;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    always_comb begin
        state_next   = state_reg;
        fmode_next   = fmode_reg;
        fret_next    = fret_reg;
        st_next      = st_reg;
        ptr_next     = ptr_reg;
        size_next    = size_reg;
        cnt_next     = cnt_reg;
        base_next    = base_reg;
        asize_next   = asize_reg;
        need_next    = need_reg;
        off_next     = off_reg;
        wa_next      = wa_reg;
        rest_next    = rest_reg;
        fsize_next   = fsize_reg;
        foff_next    = foff_reg;
        psz_next     = psz_reg;
        res_next     = res_reg;
        split_next   = split_reg;
        mv_next      = mv_reg;
        blocks_next  = blocks_reg;
        fb_next      = fb_reg;
        ub_next      = ub_reg;
        clr_next     = clr_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_tready;
        rd_en        = 1'b0;
        rd_off       = '0;
        wr_req       = 1'b0;
        wr_off       = '0;
        wr_val       = '0;

        tag   = rd_data_reg;
        bsz   = {tag[31:1], 1'b0};
        p_off = ptr_reg - base_reg - TAG_BYTES;
        p_bad = (p_off >= HEAP_LIMIT) || (p_off[1:0] != 2'b00);
        rsz   = ({1'b0, size_reg} + 33'd3) & ~33'd3;
        rneed = {1'b0, rsz} + 34'd8;
        if (rneed < 34'd12) begin
            rneed = 34'd12;
        end
        aneed = ((asize_reg[31:0] + 32'd3) & ~32'd3) + 32'd8;
        if (aneed < MIN_CHUNK) begin
            aneed = MIN_CHUNK;
        end
        prod = cnt_reg * size_reg;

        if (cfg_valid) begin
            base_next = cfg_data;
        end

        case (state_reg)
            S_CLEAR: begin
                wr_req = 1'b1;
                wr_off = 32'({clr_reg, 2'b00});
                wr_val = (clr_reg == '0 || clr_reg == IDX_W'(HEAP_WORDS - 1)) ? HEAP_LIMIT : '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(HEAP_WORDS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    ptr_next    = s_tdata[34:3];
                    size_next   = s_tdata[66:35];
                    cnt_next    = s_tdata[98:67];
                    res_next    = '0;
                    st_next     = ST_NULL;
                    blocks_next = '0;
                    fb_next     = '0;
                    ub_next     = '0;
                    mv_next     = 1'b0;
                    fmode_next  = FM_NORMAL;
                    off_next    = '0;
                    asize_next  = {1'b0, s_tdata[66:35]};
                    case (in_op)
                        OP_ALLOC:  state_next = S_A_INIT;
                        OP_FREE:   state_next = S_F_START;
                        OP_RESIZE: begin
                            if (s_tdata[34:3] == '0) begin
                                state_next = S_A_INIT;
                            end else if (s_tdata[66:35] == '0) begin
                                fmode_next = FM_ZERO;
                                state_next = S_F_START;
                            end else begin
                                state_next = S_R_START;
                            end
                        end
                        OP_CALLOC: state_next = S_MUL;
                        OP_WALK: begin
                            st_next    = ST_OK;
                            state_next = S_W_RD;
                        end
                        default:   state_next = S_OUT;
                    endcase
                end
            end
            S_MUL: begin
                asize_next = {1'b0, prod};
                state_next = S_A_INIT;
            end
            S_A_INIT: begin
                off_next  = '0;
                need_next = aneed;
                if (asize_reg == '0) begin
                    st_next    = ST_NULL;
                    state_next = S_OUT;
                end else if (asize_reg > {1'b0, HEAP_LIMIT}) begin
                    st_next    = ST_BIG;
                    state_next = S_OUT;
                end else begin
                    state_next = S_A_RD;
                end
            end
            S_A_RD: begin
                if (off_reg >= HEAP_LIMIT) begin
                    st_next    = ST_OOM;
                    state_next = S_OUT;
                end else begin
                    rd_en      = 1'b1;
                    rd_off     = off_reg;
                    state_next = S_A_CHK;
                end
            end
            S_A_CHK: begin
                if (bsz == '0 || bsz > HEAP_LIMIT) begin
                    st_next    = ST_CORRUPT;
                    state_next = S_FRESH_H;
                end else if (!tag[0] && bsz >= need_reg) begin
                    res_next = base_reg + off_reg + TAG_BYTES;
                    if (bsz - need_reg >= MIN_CHUNK) begin
                        wa_next    = need_reg;
                        rest_next  = bsz - need_reg;
                        split_next = 1'b1;
                    end else begin
                        wa_next    = bsz;
                        split_next = 1'b0;
                    end
                    state_next = S_SP_H1;
                end else begin
                    off_next   = off_reg + bsz;
                    state_next = S_A_RD;
                end
            end
            S_FRESH_H: begin
                wr_req     = 1'b1;
                wr_off     = '0;
                wr_val     = HEAP_LIMIT;
                state_next = S_FRESH_F;
            end
            S_FRESH_F: begin
                wr_req     = 1'b1;
                wr_off     = HEAP_LIMIT - TAG_BYTES;
                wr_val     = HEAP_LIMIT;
                state_next = S_OUT;
            end
            S_SP_H1: begin
                wr_req     = 1'b1;
                wr_off     = off_reg;
                wr_val     = wa_reg | 32'd1;
                state_next = S_SP_F1;
            end
            S_SP_F1: begin
                wr_req = (wa_reg >= TAG_BYTES);
                wr_off = off_reg + wa_reg - TAG_BYTES;
                wr_val = wa_reg;
                if (split_reg) begin
                    state_next = S_SP_H2;
                end else begin
                    st_next    = ST_OK;
                    fmode_next = FM_QUIET;
                    state_next = mv_reg ? S_F_START : S_OUT;
                end
            end
            S_SP_H2: begin
                wr_req     = 1'b1;
                wr_off     = off_reg + wa_reg;
                wr_val     = rest_reg;
                state_next = S_SP_F2;
            end
            S_SP_F2: begin
                wr_req     = (rest_reg >= TAG_BYTES);
                wr_off     = off_reg + wa_reg + rest_reg - TAG_BYTES;
                wr_val     = rest_reg;
                st_next    = ST_OK;
                fmode_next = FM_QUIET;
                state_next = mv_reg ? S_F_START : S_OUT;
            end
            S_F_START: begin
                if (ptr_reg == '0) begin
                    st_next    = free_final(fmode_reg, ST_NULL);
                    state_next = S_OUT;
                end else if (p_bad) begin
                    st_next    = free_final(fmode_reg, ST_BADPTR);
                    state_next = S_OUT;
                end else begin
                    rd_en      = 1'b1;
                    rd_off     = p_off;
                    foff_next  = p_off;
                    state_next = S_F_TAG;
                end
            end
            S_F_TAG: begin
                if (!tag[0]) begin
                    st_next    = free_final(fmode_reg, ST_NOTALLOC);
                    state_next = S_OUT;
                end else begin
                    fsize_next = bsz;
                    fret_next  = FR_NEXT;
                    state_next = S_FH;
                end
            end
            S_FH: begin
                wr_req     = 1'b1;
                wr_off     = foff_reg;
                wr_val     = fsize_reg;
                state_next = S_FF;
            end
            S_FF: begin
                wr_req = (fsize_reg >= TAG_BYTES);
                wr_off = foff_reg + fsize_reg - TAG_BYTES;
                wr_val = fsize_reg;
                case (fret_reg)
                    FR_NEXT: state_next = S_F_NRD;
                    FR_PREV: state_next = S_F_PRD;
                    default: begin
                        st_next    = free_final(fmode_reg, ST_OK);
                        state_next = S_OUT;
                    end
                endcase
            end
            S_F_NRD: begin
                if (foff_reg + fsize_reg < HEAP_LIMIT) begin
                    rd_en      = 1'b1;
                    rd_off     = foff_reg + fsize_reg;
                    state_next = S_F_NCHK;
                end else begin
                    state_next = S_F_PRD;
                end
            end
            S_F_NCHK: begin
                if (bsz >= MIN_CHUNK && bsz < HEAP_LIMIT && !tag[0]) begin
                    fsize_next = fsize_reg + bsz;
                    fret_next  = FR_PREV;
                    state_next = S_FH;
                end else begin
                    state_next = S_F_PRD;
                end
            end
            S_F_PRD: begin
                if (foff_reg != '0) begin
                    rd_en      = 1'b1;
                    rd_off     = foff_reg - TAG_BYTES;
                    state_next = S_F_PCHK;
                end else begin
                    st_next    = free_final(fmode_reg, ST_OK);
                    state_next = S_OUT;
                end
            end
            S_F_PCHK: begin
                if (tag >= MIN_CHUNK && tag < HEAP_LIMIT && tag <= foff_reg) begin
                    psz_next   = tag;
                    state_next = S_F_PRD2;
                end else begin
                    st_next    = free_final(fmode_reg, ST_OK);
                    state_next = S_OUT;
                end
            end
            S_F_PRD2: begin
                rd_en      = 1'b1;
                rd_off     = foff_reg - psz_reg;
                state_next = S_F_PTAG;
            end
            S_F_PTAG: begin
                if (!tag[0]) begin
                    fsize_next = fsize_reg + psz_reg;
                    foff_next  = foff_reg - psz_reg;
                    fret_next  = FR_DONE;
                    state_next = S_FH;
                end else begin
                    st_next    = free_final(fmode_reg, ST_OK);
                    state_next = S_OUT;
                end
            end
            S_R_START: begin
                if (p_bad) begin
                    st_next    = ST_BADPTR;
                    state_next = S_OUT;
                end else begin
                    rd_en      = 1'b1;
                    rd_off     = p_off;
                    off_next   = p_off;
                    state_next = S_R_TAG;
                end
            end
            S_R_TAG: begin
                if (!tag[0]) begin
                    st_next    = ST_NOTALLOC;
                    state_next = S_OUT;
                end else if (rneed <= {2'b00, bsz}) begin
                    res_next = ptr_reg;
                    st_next  = ST_OK;
                    if (bsz - rneed[31:0] >= MIN_CHUNK) begin
                        wa_next    = rneed[31:0];
                        rest_next  = bsz - rneed[31:0];
                        split_next = 1'b1;
                        state_next = S_SP_H1;
                    end else begin
                        state_next = S_OUT;
                    end
                end else begin
                    asize_next = rsz;
                    mv_next    = 1'b1;
                    state_next = S_A_INIT;
                end
            end
            S_W_RD: begin
                if (off_reg >= HEAP_LIMIT) begin
                    state_next = S_OUT;
                end else begin
                    rd_en      = 1'b1;
                    rd_off     = off_reg;
                    state_next = S_W_CHK;
                end
            end
            S_W_CHK: begin
                if (bsz == '0 || bsz > HEAP_LIMIT) begin
                    state_next = S_OUT;
                end else begin
                    if (tag[0]) begin
                        ub_next = ub_reg + bsz[12:0];
                    end else begin
                        fb_next = fb_reg + bsz[12:0];
                    end
                    blocks_next = blocks_reg + 9'd1;
                    off_next    = off_reg + bsz;
                    state_next  = S_W_RD;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {2'b00, ub_reg, fb_reg, blocks_reg, st_reg, res_reg};
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            base_reg    <= '0;
            fmode_reg   <= FM_NORMAL;
            fret_reg    <= FR_NEXT;
            split_reg   <= 1'b0;
            mv_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            base_reg    <= base_next;
            fmode_reg   <= fmode_next;
            fret_reg    <= fret_next;
            split_reg   <= split_next;
            mv_reg      <= mv_next;
            st_reg      <= st_next;
            ptr_reg     <= ptr_next;
            size_reg    <= size_next;
            cnt_reg     <= cnt_next;
            asize_reg   <= asize_next;
            need_reg    <= need_next;
            off_reg     <= off_next;
            wa_reg      <= wa_next;
            rest_reg    <= rest_next;
            fsize_reg   <= fsize_next;
            foff_reg    <= foff_next;
            psz_reg     <= psz_next;
            res_reg     <= res_next;
            blocks_reg  <= blocks_next;
            fb_reg      <= fb_next;
            ub_reg      <= ub_next;
            m_data_reg  <= m_data_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bth_checker.sv =====
// Port-level checker of the boundary-tag heap allocator, bound to the top level.
// Depends on bth_pkg and boundary_tag_heap_allocator_defines.svh.
`default_nettype none
`include "boundary_tag_heap_allocator_defines.svh"

module bth_checker import bth_pkg::*; (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata
);

    `BTH_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata))
    `BTH_ASSERT_NEXT(a_in_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `BTH_ASSERT_NOW(a_status_code, aclk, aresetn, m_tvalid, m_tdata[34:32] != 3'd7)
    `BTH_ASSERT_NOW(a_ptr_ok, aclk, aresetn, m_tvalid && m_tdata[31:0] != 32'd0,
        m_tdata[34:32] == ST_OK)
    `BTH_ASSERT_NOW(a_walk_ok, aclk, aresetn, m_tvalid && m_tdata[43:35] != 9'd0,
        m_tdata[34:32] == ST_OK && m_tdata[31:0] == 32'd0)

endmodule

bind boundary_tag_heap_allocator bth_checker u_bth_checker (.*);

`default_nettype wire

// ===== verif/boundary_tag_heap_allocator_tb.sv =====
// Self-checking testbench of the boundary-tag first-fit heap allocator.
// Predicts every result from a private copy of the tag store and heap base.
// Depends on bth_pkg and the boundary_tag_heap_allocator top level.
`timescale 1ns / 100ps
`default_nettype none

module boundary_tag_heap_allocator_tb;
    import bth_pkg::*;

    typedef struct packed {
        logic [31:0] element_count;
        logic [31:0] request_size;
        logic [31:0] pointer;
        logic [2:0]  opcode;
    } heap_req_t;

    typedef struct packed {
        logic [12:0] used_bytes;
        logic [12:0] free_bytes;
        logic [8:0]  block_count;
        logic [2:0]  status;
        logic [31:0] result_pointer;
    } heap_rsp_t;

    localparam int MAX_QUIET = 200000;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [31:0]         cfg_data;

    boundary_tag_heap_allocator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    logic [31:0] model_tags [HEAP_WORDS];
    logic [31:0] model_base;
    heap_req_t   pending_reqs [$];
    heap_rsp_t   expected_rsps [$];
    logic [31:0] live_ptrs [$];
    int          errors = 0;
    int          quiet_cycles = 0;
    bit          s_calm = 0;
    bit          m_calm = 0;
    int          m_holdoff = 0;

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic [31:0] tag_get(logic [31:0] off);
        logic [31:0] i;
        i = off >> 2;
        return (i < HEAP_WORDS) ? model_tags[i] : 32'd0;
    endfunction

    function automatic void tag_set(logic [31:0] off, logic [31:0] v);
        logic [31:0] i;
        i = off >> 2;
        if (i < HEAP_WORDS) model_tags[i] = v;
    endfunction

    function automatic void foot_set(logic [31:0] off, logic [31:0] sz);
        if (sz >= TAG_BYTES) tag_set(off + sz - TAG_BYTES, sz);
    endfunction

    function automatic void heap_clear();
        tag_set(0, HEAP_LIMIT);
        foot_set(0, HEAP_LIMIT);
    endfunction

    function automatic status_t heap_alloc(logic [63:0] size, output logic [31:0] res);
        logic [31:0] need, off, tag, bsz, rest;
        res = 0;
        if (size == 0) return ST_NULL;
        if (size > HEAP_BYTES) return ST_BIG;
        need = ((size[31:0] + 32'd3) & ~32'd3) + 2 * TAG_BYTES;
        if (need < MIN_CHUNK) need = MIN_CHUNK;
        off = 0;
        while (off < HEAP_LIMIT) begin
            tag = tag_get(off);
            bsz = tag & ~32'd1;
            if (bsz == 0 || bsz > HEAP_LIMIT) begin
                heap_clear();
                return ST_CORRUPT;
            end
            if (!tag[0] && bsz >= need) begin
                rest = bsz - need;
                if (rest >= MIN_CHUNK) begin
                    tag_set(off, need | 32'd1);
                    foot_set(off, need);
                    tag_set(off + need, rest);
                    foot_set(off + need, rest);
                end else begin
                    tag_set(off, bsz | 32'd1);
                    foot_set(off, bsz);
                end
                res = model_base + off + TAG_BYTES;
                return ST_OK;
            end
            off += bsz;
        end
        return ST_OOM;
    endfunction

    function automatic status_t ptr_lookup(logic [31:0] p, output logic [31:0] off);
        logic [31:0] o;
        o = p - model_base - TAG_BYTES;
        off = 0;
        if (o >= HEAP_LIMIT || o[1:0] != 0) return ST_BADPTR;
        if ((tag_get(o) & 32'd1) == 32'd0) return ST_NOTALLOC;
        off = o;
        return ST_OK;
    endfunction

    function automatic status_t heap_free(logic [31:0] p);
        logic [31:0] off, size, nxt, nt, nsz, psz, poff;
        status_t st;
        if (p == 0) return ST_NULL;
        st = ptr_lookup(p, off);
        if (st != ST_OK) return st;
        size = tag_get(off) & ~32'd1;
        tag_set(off, size);
        foot_set(off, size);
        nxt = off + size;
        if (nxt < HEAP_LIMIT) begin
            nt = tag_get(nxt);
            nsz = nt & ~32'd1;
            if (nsz >= MIN_CHUNK && nsz < HEAP_LIMIT && !nt[0]) begin
                size += nsz;
                tag_set(off, size);
                foot_set(off, size);
            end
        end
        if (off > 0) begin
            psz = tag_get(off - TAG_BYTES);
            if (psz >= MIN_CHUNK && psz < HEAP_LIMIT && psz <= off) begin
                poff = off - psz;
                if (poff < off && (tag_get(poff) & 32'd1) == 32'd0) begin
                    size += psz;
                    tag_set(poff, size);
                    foot_set(poff, size);
                end
            end
        end
        return ST_OK;
    endfunction

    function automatic status_t heap_resize(logic [31:0] p, logic [31:0] size,
                                            output logic [31:0] res);
        logic [31:0] off, old, n, rest;
        logic [63:0] rsz, need;
        status_t st;
        res = 0;
        if (p == 0) return heap_alloc({32'd0, size}, res);
        if (size == 0) begin
            st = heap_free(p);
            return (st == ST_OK) ? ST_NULL : st;
        end
        st = ptr_lookup(p, off);
        if (st != ST_OK) return st;
        old = tag_get(off) & ~32'd1;
        rsz = ({32'd0, size} + 64'd3) & ~64'd3;
        need = rsz + 64'd8;
        if (need < {32'd0, MIN_CHUNK}) need = {32'd0, MIN_CHUNK};
        if (need <= {32'd0, old}) begin
            n = need[31:0];
            rest = old - n;
            if (rest >= MIN_CHUNK) begin
                tag_set(off, n | 32'd1);
                foot_set(off, n);
                tag_set(off + n, rest);
                foot_set(off + n, rest);
            end
            res = p;
            return ST_OK;
        end
        st = heap_alloc(rsz, res);
        if (st != ST_OK) return st;
        void'(heap_free(p));
        return ST_OK;
    endfunction

    function automatic heap_rsp_t heap_predict(heap_req_t rq);
        heap_rsp_t r;
        logic [31:0] res, off, tag, bsz, blocks, fb, ub;
        status_t st;
        res = 0; blocks = 0; fb = 0; ub = 0;
        st = ST_NULL;
        case (rq.opcode)
            OP_ALLOC:  st = heap_alloc({32'd0, rq.request_size}, res);
            OP_FREE:   st = heap_free(rq.pointer);
            OP_RESIZE: st = heap_resize(rq.pointer, rq.request_size, res);
            OP_CALLOC: st = heap_alloc({32'd0, 32'(rq.element_count * rq.request_size)}, res);
            OP_WALK: begin
                st = ST_OK;
                off = 0;
                while (off < HEAP_LIMIT) begin
                    tag = tag_get(off);
                    bsz = tag & ~32'd1;
                    if (bsz == 0 || bsz > HEAP_LIMIT) break;
                    if (tag[0]) ub += bsz;
                    else fb += bsz;
                    blocks++;
                    off += bsz;
                end
            end
            default: st = ST_NULL;
        endcase
        if (st == ST_OK && res != 0) live_ptrs.push_back(res);
        r.result_pointer = res;
        r.status = st;
        r.block_count = blocks[8:0];
        r.free_bytes = fb[12:0];
        r.used_bytes = ub[12:0];
        return r;
    endfunction

    function automatic logic [31:0] pick_ptr();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return $urandom();
            2: return model_base + 32'($urandom_range(0, HEAP_BYTES + 8));
            default: begin
                if (live_ptrs.size() == 0) return model_base + 4;
                return live_ptrs[$urandom_range(0, live_ptrs.size() - 1)];
            end
        endcase
    endfunction

    function automatic logic [31:0] pick_size();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return $urandom();
            2: return 32'($urandom_range(1, HEAP_BYTES + 16));
            default: return 32'($urandom_range(1, 160));
        endcase
    endfunction

    // Items are built when the driver takes them so that pointers come from the
    // current live set.
    function automatic heap_req_t make_req(int kind);
        heap_req_t rq;
        rq.opcode = 3'(kind);
        rq.pointer = pick_ptr();
        rq.request_size = pick_size();
        rq.element_count = ($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(0, 8);
        return rq;
    endfunction

    always @(posedge aclk) begin
        heap_req_t nxt;
        if (!aresetn) begin
            s_tvalid <= 0;
            s_tdata <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_rsps.push_back(heap_predict(heap_req_t'(s_tdata[98:0])));
            end
            if ((!s_tvalid || s_tready) && pending_reqs.size() != 0 &&
                (s_calm || $urandom_range(0, 99) >= 17)) begin
                nxt = pending_reqs.pop_front();
                if (nxt.opcode == 3'd7 && nxt.pointer == 32'hFFFF_FFFF)
                    nxt = make_req($urandom_range(0, 9) < 9 ? $urandom_range(0, 4)
                                                            : $urandom_range(5, 7));
                s_tvalid <= 1;
                s_tdata <= S_DATA_W'(nxt);
            end else if (s_tready) begin
                s_tvalid <= 0;
            end
        end
    end

    always @(posedge aclk) begin
        heap_rsp_t got, want;
        if (!aresetn) begin
            m_tready <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = heap_rsp_t'(m_tdata[69:0]);
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end else begin
                    want = expected_rsps.pop_front();
                    if (got.result_pointer !== want.result_pointer ||
                        got.status !== want.status ||
                        got.block_count !== want.block_count ||
                        got.free_bytes !== want.free_bytes ||
                        got.used_bytes !== want.used_bytes) begin
                        $display("%0t: mismatch expected %h actual %h", $time, want, got);
                        errors++;
                    end
                end
            end
            if (m_holdoff > 0) begin
                m_holdoff <= m_holdoff - 1;
                m_tready <= 0;
            end else begin
                m_tready <= m_calm || $urandom_range(0, 99) >= 17;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= MAX_QUIET) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic drain_all();
        while (pending_reqs.size() != 0 || s_tvalid || expected_rsps.size() != 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic set_base(logic [31:0] b);
        cfg_valid <= 1;
        cfg_data <= b;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 0;
        model_base = b;
        live_ptrs.delete();
    endtask

    task automatic push(logic [2:0] op, logic [31:0] p, logic [31:0] sz, logic [31:0] cnt);
        heap_req_t rq;
        rq.opcode = op; rq.pointer = p; rq.request_size = sz; rq.element_count = cnt;
        pending_reqs.push_back(rq);
    endtask

    task automatic push_random(int n);
        repeat (n) push(3'd7, 32'hFFFF_FFFF, 0, 0);
    endtask

    initial begin
        logic [31:0] bases [4];
        bases[0] = 32'h0000_0000; bases[1] = 32'hFFFF_FFF0;
        bases[2] = 32'h8000_0000; bases[3] = 32'hFFFF_FFFF;
        aresetn = 0;
        s_tvalid = 0; s_tdata = '0; m_tready = 0; cfg_valid = 0; cfg_data = 0;
        for (int i = 0; i < HEAP_WORDS; i++) model_tags[i] = 0;
        model_base = 0;
        heap_clear();
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        set_base(32'h0000_1000);

        push(OP_WALK, 0, 0, 0);
        push(OP_ALLOC, 0, 0, 0);
        push(OP_ALLOC, 0, 1, 0);
        push(OP_ALLOC, 0, 32'hFFFF_FFFF, 0);
        push(OP_ALLOC, 0, 4097, 0);
        push(OP_ALLOC, 0, 100, 0);
        push(OP_ALLOC, 0, 40, 0);
        push(OP_FREE, 0, 0, 0);
        push(OP_FREE, 32'h1001, 0, 0);
        push(OP_FREE, 32'h0, 0, 0);
        push(OP_FREE, 32'h1004, 0, 0);
        push(OP_FREE, 32'h1004, 0, 0);
        push(OP_RESIZE, 0, 20, 0);
        push(OP_RESIZE, 32'h107C, 8, 0);
        push(OP_RESIZE, 32'h107C, 32'hFFFF_FFFF, 0);
        push(OP_RESIZE, 32'h107C, 600, 0);
        push(OP_RESIZE, 32'h1004, 0, 0);
        push(OP_CALLOC, 0, 32'h8000_0000, 2);
        push(OP_CALLOC, 0, 3, 5);
        push(OP_CALLOC, 0, 4096, 1);
        push(OP_ALLOC, 0, 4096, 0);
        push(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push(3'd7, 0, 0, 0);
        push(OP_WALK, 0, 0, 0);
        drain_all();

        for (int ph = 0; ph < 4; ph++) begin
            set_base(bases[ph]);
            if (ph == 1) s_calm = 1;
            push_random(150);
            if (ph == 2) begin
                m_holdoff = 3000;
            end
            drain_all();
            s_calm = 0;
            m_calm = (ph == 0);
            push_random(150);
            drain_all();
            m_calm = 0;
        end
        drain_all();
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

`default_nettype wire
